@@ rtl/core/akv_pkg.sv @@
// Shared types and constants for the append-only key/value table core.
// No dependencies; imported by akv_cell and append_only_key_value_table_core.
package akv_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = 5;
    localparam int FILL_OUT_W = 5;
    localparam int OP_W       = 2;
    localparam int CMP_W      = (LVL_W > CAP_W) ? LVL_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [OP_W-1:0] OP_PUT = 2'd0;
    localparam logic [OP_W-1:0] OP_GET = 2'd1;
    localparam logic [OP_W-1:0] OP_CLR = 2'd2;

    // One operation travelling down the cell chain.
    typedef struct packed {
        logic              vld;
        logic              wr;      // put that was granted a slot
        logic              is_get;
        logic              ok;      // status decided at the head (put, clear)
        logic [IDX_W-1:0]  idx;     // target slot of a granted put
        logic [LVL_W-1:0]  level;   // fill count after the operation
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        logic              hit;
        logic [DATA_W-1:0] result;
    } token_t;

endpackage

@@ rtl/core/akv_cell.sv @@
// One table slot plus one stage of the operation pipeline.
// Depends on akv_pkg for the token type and widths.
module akv_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic [akv_pkg::IDX_W-1:0] idx,
    input  akv_pkg::token_t       tok_i,
    output akv_pkg::token_t       tok_o
);
    import akv_pkg::*;

    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] value_reg;
    token_t            tok_reg;
    token_t            tok_next;
    logic              match;

    // Compare only slots below the fill level the get saw; oldest match wins.
    assign match = tok_i.vld && tok_i.is_get && !tok_i.hit
                   && (LVL_W'(idx) < tok_i.level) && (key_reg == tok_i.key);

    always_comb begin
        tok_next = tok_i;
        if (match) begin
            tok_next.hit    = 1'b1;
            tok_next.result = value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && tok_i.vld && tok_i.wr && (tok_i.idx == idx)) begin
            key_reg   <= tok_i.key;
            value_reg <= tok_i.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.vld <= 1'b0;
        end else if (adv) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_o = tok_reg;

endmodule

@@ rtl/core/append_only_key_value_table_core.sv @@
// Append-only key/value table: put, get (oldest match) and clear over a chain of cells.
// Depends on akv_pkg and akv_cell. An accepted operation passes through each cell's stage register to the result.
// Throughput: one transaction per cycle; the whole chain holds while the result stalls.
// Each cell owns one slot and compares it as the operation passes through its stage.
// Reset (aresetn low, synchronous): empties the table, capacity_limit returns to 16,
// and drops every operation in flight; slot contents stay undefined until written.
module append_only_key_value_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input transaction
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value_in
    input  logic [1:0]  s_tuser,   // [1:0] op
    // result transaction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] value_out, [36:32] fill_level, [39:37] zero
    output logic [0:0]  m_tuser,   // [0] ok
    // capacity_limit register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import akv_pkg::*;

    logic [LVL_W-1:0] fill_reg;
    logic [LVL_W-1:0] fill_next;
    logic [CAP_W-1:0] cap_reg;
    logic             adv;
    logic             s_acc;
    logic             put_ok;
    logic [OP_W-1:0]  op;
    token_t           head_tok;
    token_t           chain [DEPTH+1];
    token_t           out_tok;

    assign op = s_tuser;

    // Advance the whole chain unless the result register is held.
    assign adv       = !out_tok.vld || m_tready;
    assign s_tready  = adv;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // A put needs room under both the built depth and the programmed capacity.
    assign put_ok = (fill_reg < LVL_W'(DEPTH)) && (CMP_W'(fill_reg) < CMP_W'(cap_reg));

    // Decode the operation at the head; fill count is known only here.
    always_comb begin
        fill_next       = fill_reg;
        head_tok.vld    = s_tvalid;
        head_tok.wr     = 1'b0;
        head_tok.is_get = 1'b0;
        head_tok.ok     = 1'b0;
        head_tok.idx    = fill_reg[IDX_W-1:0];
        head_tok.key    = s_tdata[DATA_W-1:0];
        head_tok.value  = s_tdata[2*DATA_W-1:DATA_W];
        head_tok.hit    = 1'b0;
        head_tok.result = '0;
        unique case (op)
            OP_PUT: begin
                if (put_ok) begin
                    head_tok.wr = 1'b1;
                    head_tok.ok = 1'b1;
                    fill_next   = fill_reg + LVL_W'(1);
                end
            end
            OP_GET: begin
                head_tok.is_get = 1'b1;
            end
            OP_CLR: begin
                head_tok.ok = 1'b1;
                fill_next   = '0;
            end
            default: begin
                // unused code: no operation
            end
        endcase
        head_tok.level = fill_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (s_acc) begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_data;
        end
    end

    // Cell chain: operations move one slot per cycle while the chain advances, in arrival order, so a put
    // always reaches its slot before any later get does.
    assign chain[0] = head_tok;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        akv_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .idx     (IDX_W'(i)),
            .tok_i   (chain[i]),
            .tok_o   (chain[i+1])
        );
    end

    // The last cell's stage register is the result register.
    assign out_tok  = chain[DEPTH];
    assign m_tvalid = out_tok.vld;
    assign m_tuser  = out_tok.ok | out_tok.hit;
    assign m_tdata  = {3'b000, FILL_OUT_W'(out_tok.level), out_tok.result};

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= LVL_W'(DEPTH))
        else $error("fill count beyond table depth");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (op == OP_CLR) |=> fill_reg == '0)
        else $error("clear did not empty the table");

    a_put_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (op == OP_PUT) && put_ok |=> fill_reg == $past(fill_reg) + LVL_W'(1))
        else $error("granted put did not advance fill count");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(fill_reg))
        else $error("fill count moved while chain held");
`endif

endmodule
